// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the core RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define SPSL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spsl: same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define SPSL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spsl: next-cycle check failed");

`endif

// ===== rtl/core/spsl_pkg.sv =====
package spsl_pkg;

    // Default sample width
    localparam int SAMPLE_BITS_DEF = 12;

    // Fixed field widths
    localparam int GAIN_W      = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int OUT_W       = 14;
    localparam int DK_W        = 8;
    localparam int LIMV_W      = 13;
    localparam int ISUM_W      = 3;

    // Proportional multipliers
    localparam logic [DK_W-1:0] DK_LOW    = DK_W'(5);
    localparam logic [DK_W-1:0] DK_MEDIUM = DK_W'(100);
    localparam logic [DK_W-1:0] DK_STRONG = DK_W'(200);

    // Gain table codes
    localparam logic [1:0] SEL_STRONG = 2'd1;
    localparam logic [1:0] SEL_MEDIUM = 2'd2;

    // Start window: first 30 seconds
    localparam int START_SECONDS = 30;

    // Output limits in units of 1/1024
    localparam logic [LIMV_W-1:0] LIMV_TIGHT = LIMV_W'(102);
    localparam logic [LIMV_W-1:0] LIMV_HALF  = LIMV_W'(512);
    localparam logic [LIMV_W-1:0] LIMV_MID   = LIMV_W'(2048);
    localparam logic [LIMV_W-1:0] LIMV_WIDE  = LIMV_W'(5120);

    typedef enum logic [1:0] {
        LIM_TIGHT,
        LIM_HALF,
        LIM_MID,
        LIM_WIDE
    } lim_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SETPOINT  = 3'd0,
        REG_GAIN_P    = 3'd1,
        REG_GAIN_I    = 3'd2,
        REG_GAIN_D    = 3'd3,
        REG_FINE_MODE = 3'd4
    } cfg_reg_t;

    // Schedule decision for one sample
    typedef struct packed {
        logic [DK_W-1:0] dk;
        lim_t            lim;
    } sched_t;

    function automatic logic [LIMV_W-1:0] lim_value(input lim_t sel);
        logic [LIMV_W-1:0] v;
        case (sel)
            LIM_TIGHT: v = LIMV_TIGHT;
            LIM_HALF:  v = LIMV_HALF;
            LIM_MID:   v = LIMV_MID;
            LIM_WIDE:  v = LIMV_WIDE;
            default:   v = LIMV_TIGHT;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/spsl_sample_if.sv =====
interface spsl_sample_if #(
    parameter int SAMPLE_BITS = spsl_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] measured;
    logic                   power_limit_mode;
    logic [1:0]             gain_select;
    logic [7:0]             elapsed_hours;
    logic [5:0]             elapsed_minutes;
    logic [5:0]             elapsed_seconds;

    modport source (
        output valid, measured, power_limit_mode, gain_select,
               elapsed_hours, elapsed_minutes, elapsed_seconds,
        input  ready
    );
    modport sink (
        input  valid, measured, power_limit_mode, gain_select,
               elapsed_hours, elapsed_minutes, elapsed_seconds,
        output ready
    );
endinterface

// ===== rtl/core/spsl_adjust_if.sv =====
interface spsl_adjust_if;
    logic                                valid;
    logic                                ready;
    logic signed [spsl_pkg::OUT_W-1:0]   drive_adjust;

    modport source (output valid, drive_adjust, input ready);
    modport sink   (input valid, drive_adjust, output ready);
endinterface

// ===== rtl/core/spsl_cfg_if.sv =====
interface spsl_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [spsl_pkg::CFG_INDEX_W-1:0]    index;
    logic [spsl_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/spsl_sched.sv =====
module spsl_sched #(
    parameter int SAMPLE_BITS = spsl_pkg::SAMPLE_BITS_DEF
) (
    input  logic [SAMPLE_BITS-1:0]    setpoint,
    input  logic [SAMPLE_BITS-1:0]    measured,
    input  logic                      power_limit_mode,
    input  logic [1:0]                gain_select,
    input  logic [7:0]                elapsed_hours,
    input  logic [5:0]                elapsed_minutes,
    input  logic [5:0]                elapsed_seconds,
    input  logic                      fine_mode,
    output logic signed [SAMPLE_BITS:0] err_db,
    output spsl_pkg::sched_t          sched
);
    import spsl_pkg::*;

    localparam int EW = SAMPLE_BITS + 1;

    logic signed [EW-1:0] err_raw;
    logic [EW-1:0]        mag_raw;
    logic [EW-1:0]        mag_db;
    logic                 start_window;
    logic                 wide_ok;
    logic [DK_W-1:0]      dk_sel;
    lim_t                 lim_sel;

    // Raw error and its magnitude
    assign err_raw = signed'({1'b0, setpoint}) - signed'({1'b0, measured});
    assign mag_raw = err_raw[EW-1] ? EW'(-err_raw) : EW'(err_raw);

    // Deadband and multiplier choice
    always_comb
    begin
        err_db = err_raw;
        dk_sel = DK_LOW;
        if (power_limit_mode)
        begin
            if (mag_raw != EW'(3))
                dk_sel = DK_STRONG;
        end
        else if (gain_select == SEL_STRONG || gain_select == SEL_MEDIUM)
        begin
            if (mag_raw <= EW'(1))
                err_db = '0;
            else
                dk_sel = (gain_select == SEL_STRONG) ? DK_STRONG : DK_MEDIUM;
        end
    end

    assign mag_db = err_db[EW-1] ? EW'(-err_db) : EW'(err_db);

    // Limit selection from post-deadband magnitude and elapsed time
    assign start_window = (elapsed_hours == 8'd0) && (elapsed_minutes == 6'd0)
                       && (elapsed_seconds < 6'(START_SECONDS));
    assign wide_ok = fine_mode || start_window;

    always_comb
    begin
        if (mag_db >= EW'(3) && mag_db <= EW'(5))
            lim_sel = wide_ok ? LIM_MID : LIM_TIGHT;
        else if (mag_db > EW'(5))
            lim_sel = wide_ok ? LIM_WIDE : LIM_TIGHT;
        else
            lim_sel = fine_mode ? LIM_HALF : LIM_TIGHT;
    end

    // Pack the schedule decision
    assign sched = {dk_sel, lim_sel};

endmodule

// ===== rtl/core/scheduled_pid_step_limiter_core.sv =====
// Pipeline: from sample acceptance to drive_adjust valid (error stage, product stage,
// sum/clamp stage); the integrator and error history update at accept.
// Throughput: one sample per cycle unless the sink stalls; each stage moves
// whenever the stage after it is empty or moving, and the output register holds while
// the sink stalls. Reset: rst_n (async, active low) clears configuration, integrator,
// error history and all stage valid flags.
`include "assert_macros.svh"

module scheduled_pid_step_limiter_core #(
    parameter int SAMPLE_BITS = spsl_pkg::SAMPLE_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    spsl_sample_if.sink   sample,
    spsl_cfg_if.sink      cfg,
    spsl_adjust_if.source adjust
);
    import spsl_pkg::*;

    localparam int EW     = SAMPLE_BITS + 1;      // error
    localparam int DW     = EW + 1;               // error difference, clamped sum input
    localparam int ED_W   = EW + DK_W;            // error times multiplier
    localparam int PW     = GAIN_W + ED_W;        // proportional product
    localparam int IW     = GAIN_W + ISUM_W;      // integral product
    localparam int DPW    = GAIN_W + DW;          // derivative product
    localparam int ACC_W  = PW + 2;
    localparam int ACC4_W = ACC_W + 2;

    // Configuration registers
    logic [SAMPLE_BITS-1:0]   setpoint_reg;
    logic signed [GAIN_W-1:0] gain_p_reg;
    logic signed [GAIN_W-1:0] gain_i_reg;
    logic signed [GAIN_W-1:0] gain_d_reg;
    logic                     fine_mode_reg;

    // Controller state
    logic signed [ISUM_W-1:0] isum_reg;
    logic signed [EW-1:0]     last_error_reg;
    logic signed [EW-1:0]     previous_error_reg;

    // Stage valid flags and handshake
    logic v1_reg, v2_reg, v3_reg;
    logic adv1, adv2, adv3;
    logic accept;

    // Stage 1 payload
    logic signed [ED_W-1:0]   ed_reg;
    logic signed [ISUM_W-1:0] sum1_reg;
    logic signed [DW-1:0]     derr_reg;
    lim_t                     lim1_reg;

    // Stage 2 payload
    logic signed [PW-1:0]     p_reg;
    logic signed [IW-1:0]     i_reg;
    logic signed [DPW-1:0]    d_reg;
    lim_t                     lim2_reg;

    // Stage 3 payload
    logic signed [OUT_W-1:0]  out_reg;

    // Combinational signals
    logic signed [EW-1:0]     err_db;
    sched_t                   sched;
    logic signed [DW-1:0]     sum_wide;
    logic signed [ISUM_W-1:0] isum_next;
    logic signed [ED_W-1:0]   ed_next;
    logic signed [DW-1:0]     derr_next;
    logic signed [PW-1:0]     p_next;
    logic signed [IW-1:0]     i_next;
    logic signed [DPW-1:0]    d_next;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC4_W-1:0] acc4;
    logic signed [ACC4_W-1:0] lim_ext;
    logic signed [OUT_W-1:0]  out_next;

    // Pipeline flow control
    assign adv3   = !v3_reg || adjust.ready;
    assign adv2   = !v2_reg || adv3;
    assign adv1   = !v1_reg || adv2;
    assign sample.ready = adv1;
    assign accept = sample.valid && adv1;

    assign cfg.ready    = 1'b1;
    assign adjust.valid = v3_reg;
    assign adjust.drive_adjust = out_reg;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg  <= '0;
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            fine_mode_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_SETPOINT:  setpoint_reg  <= cfg.data[SAMPLE_BITS-1:0];
                REG_GAIN_P:    gain_p_reg    <= signed'(cfg.data);
                REG_GAIN_I:    gain_i_reg    <= signed'(cfg.data);
                REG_GAIN_D:    gain_d_reg    <= signed'(cfg.data);
                REG_FINE_MODE: fine_mode_reg <= cfg.data[0];
                default: ;
            endcase
        end
    end

    // Error, deadband and limit selection
    spsl_sched #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_sched (
        .setpoint         (setpoint_reg),
        .measured         (sample.measured),
        .power_limit_mode (sample.power_limit_mode),
        .gain_select      (sample.gain_select),
        .elapsed_hours    (sample.elapsed_hours),
        .elapsed_minutes  (sample.elapsed_minutes),
        .elapsed_seconds  (sample.elapsed_seconds),
        .fine_mode        (fine_mode_reg),
        .err_db           (err_db),
        .sched            (sched)
    );

    // Integrator clamp to +-2, error difference, error times multiplier
    assign sum_wide = DW'(isum_reg) + DW'(err_db);
    always_comb
    begin
        if (sum_wide >= DW'(2))
            isum_next = ISUM_W'(2);
        else if (sum_wide <= -DW'(2))
            isum_next = -ISUM_W'(2);
        else
            isum_next = ISUM_W'(sum_wide);
    end
    assign derr_next = DW'(last_error_reg) - DW'(previous_error_reg);
    assign ed_next   = ED_W'(err_db) * ED_W'(signed'({1'b0, sched.dk}));

    // State update on accept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            isum_reg           <= '0;
            last_error_reg     <= '0;
            previous_error_reg <= '0;
        end
        else if (accept)
        begin
            isum_reg           <= isum_next;
            last_error_reg     <= err_db;
            previous_error_reg <= last_error_reg;
        end
    end

    // Stage 1 registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ed_reg   <= ed_next;
            sum1_reg <= isum_next;
            derr_reg <= derr_next;
            lim1_reg <= sched.lim;
        end
    end

    // Stage 2: gain products
    assign p_next = PW'(gain_p_reg) * PW'(ed_reg);
    assign i_next = IW'(gain_i_reg) * IW'(sum1_reg);
    assign d_next = DPW'(gain_d_reg) * DPW'(derr_reg);

    always_ff @(posedge clk)
    begin
        if (v1_reg && adv2)
        begin
            p_reg    <= p_next;
            i_reg    <= i_next;
            d_reg    <= d_next;
            lim2_reg <= lim1_reg;
        end
    end

    // Stage 3: sum, scale to 1/1024 and clamp
    assign acc     = ACC_W'(p_reg) + ACC_W'(i_reg) + ACC_W'(d_reg);
    assign acc4    = ACC4_W'(acc) <<< 2;
    assign lim_ext = ACC4_W'(signed'({1'b0, lim_value(lim2_reg)}));

    always_comb
    begin
        if (acc4 >= lim_ext)
            out_next = OUT_W'(lim_ext);
        else if (acc4 <= -lim_ext)
            out_next = OUT_W'(-lim_ext);
        else
            out_next = acc4[OUT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (v2_reg && adv3)
            out_reg <= out_next;
    end

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= sample.valid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
        end
    end

    // Checks
    `SPSL_ASSERT_IMP(a_isum_range, clk, rst_n, 1'b1,
        (isum_reg >= -ISUM_W'(2) && isum_reg <= ISUM_W'(2)))
    `SPSL_ASSERT_IMP(a_out_bounded, clk, rst_n, v3_reg,
        (out_reg >= -signed'(OUT_W'(LIMV_WIDE)) && out_reg <= signed'(OUT_W'(LIMV_WIDE))))
    `SPSL_ASSERT_NXT(a_last_err_load, clk, rst_n, accept,
        (last_error_reg == $past(err_db)))
    `SPSL_ASSERT_NXT(a_prev_err_shift, clk, rst_n, accept,
        (previous_error_reg == $past(last_error_reg)))

endmodule
